>>> hdl/lp2c_pkg.sv
package lp2c_pkg;

   localparam int CORDIC_ITERS = 30;
   localparam int ITERS_PER_STAGE = 2;
   localparam int CORDIC_STAGES = CORDIC_ITERS / ITERS_PER_STAGE;

   // CORDIC datapath width: Q30 values plus sign and one guard bit.
   localparam int CW = 33;

   localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic signed [16:0] COORD_LIMIT = 17'sd65535;
   localparam logic signed [16:0] NO_RETURN = -17'sd1;

   // Register indexes on the configuration port.
   localparam logic REG_START_ANGLE = 1'b0;
   localparam logic REG_ANGLE_STEP = 1'b1;

   // Quadrant codes from the top two angle bits.
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;

   localparam logic [29:0] ATAN_BAU [0:CORDIC_ITERS-1] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
      30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
      30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
      30'd20, 30'd10, 30'd5, 30'd3, 30'd1
   };

   typedef struct packed {
      logic               null_pt;
      logic signed [16:0] range_mm;
   } side_type;

endpackage

>>> hdl/lp2c_angle.sv
module lp2c_angle #(
   parameter int MAX_BEAMS = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [9:0]          beam_index,
   input  logic signed [16:0]  range_mm,
   input  logic [31:0]         start_angle,
   input  logic [31:0]         angle_step,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [31:0]         angle,
   output lp2c_pkg::side_type  side
);

   logic               valid_ff;
   logic [31:0]        angle_ff, angle_in;
   lp2c_pkg::side_type side_ff, side_in;
   logic [41:0]        prod;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      prod = 42'(beam_index) * 42'(angle_step);
      angle_in = start_angle + prod[31:0];
      side_in.range_mm = range_mm;
      side_in.null_pt = (range_mm == lp2c_pkg::NO_RETURN) ||
                        ({22'd0, beam_index} >= 32'(MAX_BEAMS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         angle_ff <= angle_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign angle = angle_ff;
   assign side = side_ff;

endmodule

>>> hdl/lp2c_cordic.sv
module lp2c_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [31:0]                         angle,
   input  lp2c_pkg::side_type                  in_side,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [lp2c_pkg::CW-1:0]      cos_q30,
   output logic signed [lp2c_pkg::CW-1:0]      sin_q30,
   output logic [1:0]                          quad,
   output lp2c_pkg::side_type                  out_side
);

   localparam int NS = lp2c_pkg::CORDIC_STAGES;
   localparam int CW = lp2c_pkg::CW;

   logic [NS-1:0]         valid_ff;
   logic [NS:0]           rdy;
   logic signed [CW-1:0]  x_ff [NS];
   logic signed [CW-1:0]  y_ff [NS];
   logic signed [CW-1:0]  z_ff [NS];
   logic [1:0]            q_ff [NS];
   lp2c_pkg::side_type    side_ff [NS];

   assign rdy[NS] = out_ready;
   assign in_ready = rdy[0];

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic signed [CW-1:0] x_prev, y_prev, z_prev;
      logic signed [CW-1:0] x_in, y_in, z_in;
      logic [1:0]           q_prev;
      lp2c_pkg::side_type   side_prev;
      logic                 valid_prev;

      if (s == 0) begin : g_first
         assign x_prev = lp2c_pkg::CORDIC_GAIN;
         assign y_prev = '0;
         assign z_prev = {3'b000, angle[29:0]};
         assign q_prev = angle[31:30];
         assign side_prev = in_side;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign x_prev = x_ff[s-1];
         assign y_prev = y_ff[s-1];
         assign z_prev = z_ff[s-1];
         assign q_prev = q_ff[s-1];
         assign side_prev = side_ff[s-1];
         assign valid_prev = valid_ff[s-1];
      end

      assign rdy[s] = !valid_ff[s] || rdy[s+1];

      always_comb begin
         logic signed [CW-1:0] dx, dy, at;
         x_in = x_prev;
         y_in = y_prev;
         z_in = z_prev;
         for (int k = 0; k < lp2c_pkg::ITERS_PER_STAGE; k++) begin
            dx = y_in >>> (s * lp2c_pkg::ITERS_PER_STAGE + k);
            dy = x_in >>> (s * lp2c_pkg::ITERS_PER_STAGE + k);
            at = {3'b000, lp2c_pkg::ATAN_BAU[s * lp2c_pkg::ITERS_PER_STAGE + k]};
            if (!z_in[CW-1]) begin
               x_in = x_in - dx;
               y_in = y_in + dy;
               z_in = z_in - at;
            end else begin
               x_in = x_in + dx;
               y_in = y_in - dy;
               z_in = z_in + at;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            valid_ff[s] <= valid_prev;
         end
         if (rdy[s]) begin
            x_ff[s] <= x_in;
            y_ff[s] <= y_in;
            z_ff[s] <= z_in;
            q_ff[s] <= q_prev;
            side_ff[s] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign cos_q30 = x_ff[NS-1];
   assign sin_q30 = y_ff[NS-1];
   assign quad = q_ff[NS-1];
   assign out_side = side_ff[NS-1];

endmodule

>>> hdl/lp2c_scale.sv
module lp2c_scale (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic signed [lp2c_pkg::CW-1:0]  cos_q30,
   input  logic signed [lp2c_pkg::CW-1:0]  sin_q30,
   input  logic [1:0]                      quad,
   input  lp2c_pkg::side_type              in_side,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic                            point_valid,
   output logic signed [16:0]              point_x,
   output logic signed [16:0]              point_y
);

   localparam int CW = lp2c_pkg::CW;
   localparam int PW = CW + 17;

   logic [2:0]            valid_ff;
   logic [2:0]            rdy;

   // Stage A: quadrant fold.
   logic signed [CW-1:0]  c_ff, c_in, s_ff, s_in;
   lp2c_pkg::side_type    side_a_ff;
   // Stage B: products.
   logic signed [PW-1:0]  px_ff, px_in, py_ff, py_in;
   logic                  null_b_ff;
   // Stage C: rounded, saturated output.
   logic                  pv_ff;
   logic signed [16:0]    x_ff, x_in, y_ff, y_in;

   assign rdy[2] = !valid_ff[2] || out_ready;
   assign rdy[1] = !valid_ff[1] || rdy[2];
   assign rdy[0] = !valid_ff[0] || rdy[1];
   assign in_ready = rdy[0];

   always_comb begin
      case (quad)
         lp2c_pkg::QUAD_0: begin
            c_in = cos_q30;
            s_in = sin_q30;
         end
         lp2c_pkg::QUAD_1: begin
            c_in = -sin_q30;
            s_in = cos_q30;
         end
         lp2c_pkg::QUAD_2: begin
            c_in = -cos_q30;
            s_in = -sin_q30;
         end
         default: begin
            c_in = sin_q30;
            s_in = -cos_q30;
         end
      endcase
   end

   assign px_in = PW'(side_a_ff.range_mm) * PW'(c_ff);
   assign py_in = PW'(side_a_ff.range_mm) * PW'(s_ff);

   function automatic logic signed [16:0] round_sat(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] sum;
      logic signed [PW-31:0] r;
      sum = p + (PW'(1) <<< 29);
      r = sum[PW-1:30];
      if (r > (PW-30)'(lp2c_pkg::COORD_LIMIT)) begin
         round_sat = lp2c_pkg::COORD_LIMIT;
      end else if (r < -(PW-30)'(lp2c_pkg::COORD_LIMIT)) begin
         round_sat = -lp2c_pkg::COORD_LIMIT;
      end else begin
         round_sat = r[16:0];
      end
   endfunction

   always_comb begin
      if (null_b_ff) begin
         x_in = '0;
         y_in = '0;
      end else begin
         x_in = round_sat(px_ff);
         y_in = round_sat(py_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) valid_ff[0] <= in_valid;
         if (rdy[1]) valid_ff[1] <= valid_ff[0];
         if (rdy[2]) valid_ff[2] <= valid_ff[1];
      end
      if (rdy[0]) begin
         c_ff <= c_in;
         s_ff <= s_in;
         side_a_ff <= in_side;
      end
      if (rdy[1]) begin
         px_ff <= px_in;
         py_ff <= py_in;
         null_b_ff <= side_a_ff.null_pt;
      end
      if (rdy[2]) begin
         pv_ff <= !null_b_ff;
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign point_valid = pv_ff;
   assign point_x = x_ff;
   assign point_y = y_ff;

endmodule

>>> hdl/lidar_polar_to_cartesian_unit.sv
// An accepted request beat passes 1 angle stage, 15 CORDIC stages of two iterations
// each and 3 scaling stages on its way to its response beat. Throughput: one beat
// per cycle unless rsp_tready stalls; every stage holds its own valid bit, so
// bubbles close up under backpressure and a new beat enters whenever stage one frees.
// Reset clears all valid bits and both angle registers; data registers are not reset.
module lidar_polar_to_cartesian_unit #(
   parameter int MAX_BEAMS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // APB-style configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [9:0] beam_index, [26:10] range_mm, rest zero
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [16:0] point_x, [33:17] point_y, rest zero
   output logic        rsp_tuser    // [0] point_valid
);

   logic [31:0] start_angle_ff, angle_step_ff;
   logic        csr_wr;

   logic               ang_valid, ang_ready;
   logic [31:0]        ang_angle;
   lp2c_pkg::side_type ang_side;

   logic                              cor_valid, cor_ready;
   logic signed [lp2c_pkg::CW-1:0]    cor_cos, cor_sin;
   logic [1:0]                        cor_quad;
   lp2c_pkg::side_type                cor_side;

   logic               pt_valid;
   logic signed [16:0] pt_x, pt_y;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_angle_ff <= '0;
         angle_step_ff <= '0;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            lp2c_pkg::REG_START_ANGLE: start_angle_ff <= csr_pwdata;
            lp2c_pkg::REG_ANGLE_STEP: angle_step_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         lp2c_pkg::REG_START_ANGLE: csr_prdata = start_angle_ff;
         lp2c_pkg::REG_ANGLE_STEP: csr_prdata = angle_step_ff;
         default: csr_prdata = '0;
      endcase
   end

   lp2c_angle #(.MAX_BEAMS(MAX_BEAMS)) u_angle (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .beam_index  (req_tdata[9:0]),
      .range_mm    (req_tdata[26:10]),
      .start_angle (start_angle_ff),
      .angle_step  (angle_step_ff),
      .out_valid   (ang_valid),
      .out_ready   (ang_ready),
      .angle       (ang_angle),
      .side        (ang_side)
   );

   lp2c_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ang_valid),
      .in_ready  (ang_ready),
      .angle     (ang_angle),
      .in_side   (ang_side),
      .out_valid (cor_valid),
      .out_ready (cor_ready),
      .cos_q30   (cor_cos),
      .sin_q30   (cor_sin),
      .quad      (cor_quad),
      .out_side  (cor_side)
   );

   lp2c_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (cor_valid),
      .in_ready    (cor_ready),
      .cos_q30     (cor_cos),
      .sin_q30     (cor_sin),
      .quad        (cor_quad),
      .in_side     (cor_side),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .point_valid (pt_valid),
      .point_x     (pt_x),
      .point_y     (pt_y)
   );

   assign rsp_tdata = {6'd0, pt_y, pt_x};
   assign rsp_tuser = pt_valid;

   // A null point always carries zero coordinates.
   a_null_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[33:0] == 34'd0))
      else $error("null point with nonzero coordinates");

   // Saturation never lets the most negative 17-bit code through.
   a_x_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[16:0] != 17'h10000))
      else $error("point_x outside saturation range");

   a_y_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[33:17] != 17'h10000))
      else $error("point_y outside saturation range");

   // The output register must free up for new work once its beat is taken.
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |-> cor_ready)
      else $error("pipeline stalled while output drained");

endmodule

>>> tb/lidar_polar_to_cartesian_unit_test.sv
module lidar_polar_to_cartesian_unit_test;

   localparam int BEAMS = 1024;
   localparam int STEPS = 30;
   localparam int HOLD_CYCLES = 120;
   localparam int STALL_LIMIT = 3000;
   localparam int TAIL_CYCLES = 40;
   localparam int PHASE_SAMPLES = 235;

   // Arctangent of 2^-i in binary angle units, 2^32 being one full turn.
   localparam longint ATAN_TURNS [STEPS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
      81, 41, 20, 10, 5, 3, 1
   };

   typedef struct {
      logic [9:0]         beam;
      logic signed [16:0] range_mm;
      bit                 drain;
   } scan_sample_type;

   typedef struct packed {
      logic               valid;
      logic signed [16:0] x;
      logic signed [16:0] y;
   } point_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [9:0] beam_index, [26:10] range_mm, rest zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [16:0] point_x, [33:17] point_y, rest zero
   logic        rsp_tuser;   // [0] point_valid

   scan_sample_type sample_q[$];
   point_type       point_q[$];

   logic [31:0] cfg_start;
   logic [31:0] cfg_step;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          hold_asked;
   int          hold_served;
   int          hold_left;
   logic        req_taken;
   int          idle_cycles;
   int          errors;
   int          csr_errors;
   int          points;
   int          nulls;
   int          settings;

   lidar_polar_to_cartesian_unit #(.MAX_BEAMS(BEAMS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint clamp_mm(longint v);
      if (v > lp2c_pkg::COORD_LIMIT) return lp2c_pkg::COORD_LIMIT;
      if (v < -lp2c_pkg::COORD_LIMIT) return -lp2c_pkg::COORD_LIMIT;
      return v;
   endfunction

   // Null check, beam angle, CORDIC rotation of the residual inside the quadrant, then
   // scaling of the distance with rounding of halves upward and clamping to the limit.
   function automatic point_type polar_to_point(logic [9:0] beam,
                                                logic signed [16:0] range_mm);
      point_type   pt;
      logic [31:0] angle;
      longint      range_val, x, y, z, dx, dy, cs, sn;
      pt.valid = 1'b0;
      pt.x = '0;
      pt.y = '0;
      if (range_mm == lp2c_pkg::NO_RETURN || beam >= BEAMS) return pt;
      range_val = range_mm;
      angle = cfg_start + cfg_step * 32'(beam);
      x = lp2c_pkg::CORDIC_GAIN;
      y = 0;
      z = angle[29:0];
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ATAN_TURNS[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ATAN_TURNS[i];
         end
      end
      case (angle[31:30])
         lp2c_pkg::QUAD_0: begin
            cs = x;
            sn = y;
         end
         lp2c_pkg::QUAD_1: begin
            cs = -y;
            sn = x;
         end
         lp2c_pkg::QUAD_2: begin
            cs = -x;
            sn = -y;
         end
         default: begin
            cs = y;
            sn = -x;
         end
      endcase
      pt.valid = 1'b1;
      pt.x = 17'(clamp_mm((range_val * cs + (64'sd1 <<< 29)) >>> 30));
      pt.y = 17'(clamp_mm((range_val * sn + (64'sd1 <<< 29)) >>> 30));
      return pt;
   endfunction

   always @(negedge clock) begin : drive
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         // A beat marked for draining waits until every earlier point is back.
         if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct
             && !(sample_q[0].drain && point_q.size() != 0)) begin
            req_tvalid <= 1'b1;
            req_tdata <= {5'd0, sample_q[0].range_mm, sample_q[0].beam};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : receive
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
         hold_served <= 0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_asked) begin
         hold_served <= hold_served + 1;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : observe
      point_type want;
      if (reset) begin
         req_taken <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            point_q.push_back(polar_to_point(req_tdata[9:0], req_tdata[26:10]));
            void'(sample_q.pop_front());
         end
         if (rsp_tvalid && rsp_tready) begin
            if (point_q.size() == 0) begin
               $error("response beat with no point pending: tdata=%h tuser=%b",
                      rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               want = point_q.pop_front();
               points++;
               if (!want.valid) nulls++;
               if (rsp_tuser !== want.valid) begin
                  $error("point_valid: expected %0d, actual %0d", want.valid, rsp_tuser);
                  errors++;
               end
               if (rsp_tdata[16:0] !== want.x) begin
                  $error("point_x: expected %0d, actual %0d", want.x,
                         $signed(rsp_tdata[16:0]));
                  errors++;
               end
               if (rsp_tdata[33:17] !== want.y) begin
                  $error("point_y: expected %0d, actual %0d", want.y,
                         $signed(rsp_tdata[33:17]));
                  errors++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles == STALL_LIMIT) begin
            $display("lidar_polar_to_cartesian_unit_test: done, errors");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   task automatic csr_write(input logic index, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (index == lp2c_pkg::REG_START_ANGLE) cfg_start = value;
      else cfg_step = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic csr_check(input logic index, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {index, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== value) begin
         $error("register %0d: expected %h, actual %h", index, value, csr_prdata);
         csr_errors++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_angles(input logic [31:0] start, input logic [31:0] step);
      csr_write(lp2c_pkg::REG_START_ANGLE, start);
      csr_write(lp2c_pkg::REG_ANGLE_STEP, step);
      csr_check(lp2c_pkg::REG_START_ANGLE, start);
      csr_check(lp2c_pkg::REG_ANGLE_STEP, step);
      settings++;
   endtask

   task automatic add_sample(input logic [9:0] beam, input logic signed [16:0] range_mm,
                             input bit drain);
      scan_sample_type s;
      s.beam = beam;
      s.range_mm = range_mm;
      s.drain = drain;
      sample_q.push_back(s);
   endtask

   // Every beat yields a point, so an empty expectation queue means an idle pipeline.
   task automatic wait_drained();
      while (sample_q.size() != 0 || req_tvalid || point_q.size() != 0) @(posedge clock);
   endtask

   task automatic run_scan(input logic [31:0] start, input logic [31:0] step,
                           input int send_pct, input int recv_pct, input bit hold,
                           input bit pause);
      logic signed [16:0] r;
      set_angles(start, step);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
         case ($urandom_range(9))
            0: r = lp2c_pkg::NO_RETURN;
            1: r = 17'sd65535 - 17'($urandom_range(15));
            2: r = -17'sd65536 + 17'($urandom_range(15));
            3: r = 17'($urandom_range(255));
            default: r = 17'($urandom);
         endcase
         add_sample(10'($urandom), r, pause && n == PHASE_SAMPLES / 2);
      end
      if (hold) hold_asked++;
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      cfg_start = '0;
      cfg_step = '0;
      send_idle_pct = 23;
      recv_idle_pct = 54;
      hold_asked = 0;
      errors = 0;
      csr_errors = 0;
      points = 0;
      nulls = 0;
      settings = 1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset angles: every beam points along x; field extremes and no-return.
      csr_check(lp2c_pkg::REG_START_ANGLE, '0);
      csr_check(lp2c_pkg::REG_ANGLE_STEP, '0);
      add_sample(10'd0, 17'sd0, 1'b0);
      add_sample(10'd1023, 17'sd65535, 1'b0);
      add_sample(10'd5, lp2c_pkg::NO_RETURN, 1'b0);
      add_sample(10'd0, -17'sd65536, 1'b0);
      add_sample(10'd7, -17'sd2, 1'b0);
      add_sample(10'd1023, 17'sd1, 1'b0);
      wait_drained();

      // Quarter turn per beam: exact quadrant boundaries, then their midpoints.
      set_angles(32'h0000_0000, 32'h4000_0000);
      for (int b = 0; b < 4; b++) add_sample(10'(b), 17'sd65535, 1'b0);
      for (int b = 1; b < 4; b++) add_sample(10'(b), -17'sd65536, 1'b0);
      wait_drained();
      set_angles(32'h2000_0000, 32'h4000_0000);
      for (int b = 0; b < 4; b++) add_sample(10'(b), 17'sd40000, 1'b0);
      add_sample(10'd1023, 17'sd1, 1'b0);
      add_sample(10'd2, lp2c_pkg::NO_RETURN, 1'b0);
      wait_drained();

      run_scan(32'hFFFF_FFFF, 32'h7FFF_FFFF, 23, 54, 1'b0, 1'b0);
      run_scan($urandom, 32'h8000_0000, 23, 54, 1'b1, 1'b0);
      run_scan($urandom, $urandom, 54, 23, 1'b0, 1'b1);
      run_scan(32'h0000_0000, 32'h0000_0000, 54, 23, 1'b0, 1'b0);
      run_scan($urandom, 32'($urandom_range(1 << 23) - (1 << 22)), 0, 0, 1'b0, 1'b0);
      run_scan($urandom, $urandom, 0, 0, 1'b1, 1'b0);

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("converted %0d samples (%0d null points) under %0d angle settings,",
               points, nulls, settings);
      $display("with random stalls on both streams, a long output stall and a drain pause");
      if (errors == 0 && csr_errors == 0 && point_q.size() == 0) begin
         $display("lidar_polar_to_cartesian_unit_test: done, clean");
      end else begin
         $display("lidar_polar_to_cartesian_unit_test: done, errors");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/lp2c_pkg.sv
hdl/lp2c_angle.sv
hdl/lp2c_cordic.sv
hdl/lp2c_scale.sv
hdl/lidar_polar_to_cartesian_unit.sv
tb/lidar_polar_to_cartesian_unit_test.sv
